// ===== rtl/rls_pkg.sv =====
// ----------------------------------------------------------------------------
// Radio link supervisor package
// Shared request and result types, register indexes and reset values.
// ----------------------------------------------------------------------------
package rls_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 8;

  typedef logic [CfgIndexWidth-1:0] cfg_index_t;
  typedef logic [CfgDataWidth-1:0]  byte_t;

  localparam cfg_index_t REG_TIMEOUT_RELOAD     = 3'd0;
  localparam cfg_index_t REG_RESTART_COUNT      = 3'd1;
  localparam cfg_index_t REG_RESET_RELEASE_STEP = 3'd2;
  localparam cfg_index_t REG_INIT_STEP          = 3'd3;
  localparam cfg_index_t REG_ONLINE_AFTER       = 3'd4;
  localparam cfg_index_t REG_WRAP_STEP          = 3'd5;
  localparam cfg_index_t REG_LOST_AFTER         = 3'd6;

  localparam byte_t TIMEOUT_RELOAD_RST     = 8'h0f;
  localparam byte_t RESTART_COUNT_RST      = 8'h21;
  localparam byte_t RESET_RELEASE_STEP_RST = 8'd10;
  localparam byte_t INIT_STEP_RST          = 8'd20;
  localparam byte_t ONLINE_AFTER_RST       = 8'd25;
  localparam byte_t WRAP_STEP_RST          = 8'hf1;
  localparam byte_t LOST_AFTER_RST         = 8'd4;

  typedef struct packed {
    logic reply_seen;
    logic mode_pin;
    logic pin_change;
  } tick_req_t;

  typedef struct packed {
    logic  timeout_fired;
    logic  request_info;
    logic  config_pin;
    logic  radio_reset_pin;
    logic  init_strobe_a;
    logic  init_strobe_b;
    logic  link_online;
    logic  clear_pin_change;
    byte_t tick_count;
  } tick_rsp_t;

endpackage

// ===== rtl/radio_link_supervisor.sv =====
// ----------------------------------------------------------------------------
// Radio link supervisor
// Each request is one timer tick. The block keeps the reply timeout, the
// forward/config pin, the radio restart sequence and the link online state,
// and returns one result per tick.
//
// Usage: a tick request (reply flag, mode pin, pin-change flag) is taken on
// in_valid and in_ready. Its result appears on out_data with out_valid in
// the next cycle and is held until out_ready takes it. While out_ready is
// high a new request can be taken in every cycle, so the sustained rate is
// one tick per cycle; the only storage between the two sides is the single
// result register, and a request is taken whenever that register is empty
// or is being emptied in the same cycle. When the receiver stalls, in_ready
// falls after one result is waiting and no state changes until it is taken.
// Configuration registers are written via cfg_write, cfg_index and cfg_data
// by the user only while no tick is in flight, unenforced by the block.
// An index beyond the list is ignored. Reset clears the result register and
// resets all state: reload 15, restart 33, radio reset released, offline.
// ----------------------------------------------------------------------------
module radio_link_supervisor (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rls_pkg::tick_req_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rls_pkg::tick_rsp_t out_data,
  input  logic               cfg_write,
  input  rls_pkg::cfg_index_t cfg_index,
  input  rls_pkg::byte_t     cfg_data
);
  import rls_pkg::*;

  byte_t timeout_reload;
  byte_t restart_count;
  byte_t reset_release_step;
  byte_t init_step;
  byte_t online_after;
  byte_t wrap_step;
  byte_t lost_after;

  byte_t timeout_left, timeout_left_next;
  byte_t radio_step, radio_step_next;
  byte_t active_run, active_run_next;
  byte_t ticks, ticks_next;
  logic  online_flag, online_flag_next;
  logic  forward_flag, forward_flag_next;
  logic  reset_level, reset_level_next;

  tick_rsp_t rsp_next;
  byte_t     step_inc;
  byte_t     run_inc;
  byte_t     countdown;
  logic      accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_reload     <= TIMEOUT_RELOAD_RST;
      restart_count      <= RESTART_COUNT_RST;
      reset_release_step <= RESET_RELEASE_STEP_RST;
      init_step          <= INIT_STEP_RST;
      online_after       <= ONLINE_AFTER_RST;
      wrap_step          <= WRAP_STEP_RST;
      lost_after         <= LOST_AFTER_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TIMEOUT_RELOAD:     timeout_reload     <= cfg_data;
        REG_RESTART_COUNT:      restart_count      <= cfg_data;
        REG_RESET_RELEASE_STEP: reset_release_step <= cfg_data;
        REG_INIT_STEP:          init_step          <= cfg_data;
        REG_ONLINE_AFTER:       online_after       <= cfg_data;
        REG_WRAP_STEP:          wrap_step          <= cfg_data;
        REG_LOST_AFTER:         lost_after         <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    rsp_next          = '0;
    ticks_next        = ticks + 8'd1;
    timeout_left_next = timeout_left;
    radio_step_next   = radio_step;
    active_run_next   = active_run;
    online_flag_next  = online_flag;
    forward_flag_next = forward_flag;
    reset_level_next  = reset_level;
    step_inc          = radio_step + 8'd1;
    run_inc           = active_run + 8'd1;

    countdown = (timeout_left != 8'd0) ? timeout_left - 8'd1 : 8'd0;
    timeout_left_next = countdown;
    if (countdown == 8'd0) begin
      rsp_next.timeout_fired = 1'b1;
      rsp_next.request_info  = 1'b1;
      timeout_left_next      = timeout_reload;
    end

    if (in_data.reply_seen) begin
      rsp_next.request_info = 1'b1;
      timeout_left_next     = timeout_reload;
      forward_flag_next     = !(forward_flag && online_flag);
    end

    if (!online_flag && !in_data.mode_pin) begin
      radio_step_next = step_inc;
      if (step_inc == 8'd1) begin
        reset_level_next = 1'b0;
      end else if (step_inc == reset_release_step) begin
        reset_level_next = 1'b1;
      end else if (step_inc == init_step) begin
        rsp_next.init_strobe_a = 1'b1;
      end else if (step_inc == init_step + 8'd1) begin
        rsp_next.init_strobe_b = 1'b1;
      end else if (step_inc == wrap_step) begin
        radio_step_next = 8'd0;
      end else if (in_data.pin_change) begin
        rsp_next.clear_pin_change = 1'b1;
        if (step_inc > online_after) begin
          online_flag_next = 1'b1;
        end
      end
    end else if (in_data.pin_change) begin
      active_run_next = run_inc;
      if (run_inc == lost_after) begin
        online_flag_next = 1'b0;
      end
      rsp_next.clear_pin_change = 1'b1;
      radio_step_next           = restart_count;
    end else begin
      active_run_next = 8'd0;
    end

    rsp_next.config_pin      = forward_flag_next;
    rsp_next.radio_reset_pin = reset_level_next;
    rsp_next.link_online     = online_flag_next;
    rsp_next.tick_count      = ticks_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_left <= TIMEOUT_RELOAD_RST;
      radio_step   <= RESTART_COUNT_RST;
      active_run   <= '0;
      ticks        <= '0;
      online_flag  <= 1'b0;
      forward_flag <= 1'b0;
      reset_level  <= 1'b1;
    end else if (accept) begin
      timeout_left <= timeout_left_next;
      radio_step   <= radio_step_next;
      active_run   <= active_run_next;
      ticks        <= ticks_next;
      online_flag  <= online_flag_next;
      forward_flag <= forward_flag_next;
      reset_level  <= reset_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= rsp_next;
    end
  end

  // An accepted tick always leaves a result waiting in the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted tick produced no result");

  // The two init strobes come from adjacent steps and never share a tick.
  a_strobes_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.init_strobe_a && out_data.init_strobe_b))
    else $error("both init strobes raised on one tick");

  // A timeout always raises an info request.
  a_timeout_requests: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.timeout_fired |-> out_data.request_info)
    else $error("timeout without info request");

  // Going online consumes pin activity on that same tick.
  a_online_on_activity: assert property (@(posedge clk) disable iff (rst)
    $rose(online_flag) |-> out_data.clear_pin_change)
    else $error("link went online without pin activity");

  // The result shown always matches the state kept for the next tick.
  a_result_tracks_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.link_online == online_flag)
                  && (out_data.tick_count == ticks)
                  && (out_data.config_pin == forward_flag))
    else $error("result register disagrees with supervisor state");

endmodule
